### sv/fsmatch_pkg.sv
// Shared types and constants for the first-substring-match block.
// Holds the item structs, status and operation codes, and the window control struct.
// No dependencies; every other file refers to it by scoped names.
package fsmatch_pkg;

   localparam int MAX_PATTERN_DEF = 64;
   localparam int OFFSET_W        = 31;
   localparam int STATUS_W        = 2;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

   localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_PATTERN = 2'd2;

   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TARGET  = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] match_offset;
   } rsp_type;

   // Control from the sequencing logic to the pattern/window compare unit.
   typedef struct packed {
      logic       pat_shift;
      logic       tgt_shift;
      logic [7:0] data_byte;
   } win_ctl_type;

endpackage

### sv/fsmatch_window.sv
// Pattern and target window shift registers with the parallel compare.
// Uses fsmatch_pkg for the control struct.
// The pattern is held newest byte first, so it lines up with the target window.
module fsmatch_window #(
   parameter int MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEF,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
   input  logic                      clock,
   input  fsmatch_pkg::win_ctl_type  win_ctl,
   input  logic [LEN_W-1:0]          pat_len,
   output logic                      match
);

   logic [7:0] pat_ff [MAX_PATTERN];
   logic [7:0] pat_in [MAX_PATTERN];
   logic [7:0] win_ff [MAX_PATTERN];
   logic [7:0] win_in [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] pos_ok;

   // Shift in the new byte at position zero; position j of the aligned pattern holds
   // pattern byte len-1-j, which faces target window position j.
   always_comb begin
      pat_in[0] = win_ctl.pat_shift ? win_ctl.data_byte : pat_ff[0];
      win_in[0] = win_ctl.tgt_shift ? win_ctl.data_byte : win_ff[0];
      for (int j = 1; j < MAX_PATTERN; j++) begin
         pat_in[j] = win_ctl.pat_shift ? pat_ff[j-1] : pat_ff[j];
         win_in[j] = win_ctl.tgt_shift ? win_ff[j-1] : win_ff[j];
      end
   end

   // Compare against the window as it stands after the incoming target byte.
   always_comb begin
      pos_ok[0] = (win_ctl.data_byte == pat_ff[0]) || (pat_len == '0);
      for (int j = 1; j < MAX_PATTERN; j++) begin
         pos_ok[j] = (win_ff[j-1] == pat_ff[j]) || (LEN_W'(j) >= pat_len);
      end
   end

   assign match = &pos_ok;

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      win_ff <= win_in;
   end

endmodule

### sv/first_substring_match.sv
// First substring match: an accepted item waits in the input register, then one
// compare/update pass writes any result it produces into the result register.
// Throughput is one item per cycle while the result side does not stall; the full-window compare is combinational.
// Synchronous active-high reset clears all control state and starts a new pattern;
// the pattern and target shift registers are not reset.
module first_substring_match #(
   parameter int MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fsmatch_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fsmatch_pkg::rsp_type rsp_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int OFS_W = fsmatch_pkg::OFFSET_W;

   // Input register: holds one accepted item until the compare pass takes it.
   logic                 s1_valid_ff, s1_valid_in;
   fsmatch_pkg::req_type s1_item_ff,  s1_item_in;

   // Search state.
   logic [LEN_W-1:0] len_ff,     len_in;
   logic             ovf_ff,     ovf_in;
   logic             restart_ff, restart_in;
   logic [OFS_W-1:0] seen_ff,    seen_in;
   logic             matched_ff, matched_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   fsmatch_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   fsmatch_pkg::win_ctl_type win_ctl;
   logic                     win_match;
   logic                     go;
   logic                     req_accept;
   logic                     found_hit;
   logic                     pat_ok;
   logic                     was_sat;
   logic [OFS_W-1:0]         seen_next;
   logic [LEN_W-1:0]         len_eff;

   // The compare pass runs whenever an item waits and the result register is free
   // or being emptied this cycle, so input stalls only behind a stalled result.
   assign go         = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !go;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_data;
      end else if (go) begin
         s1_valid_in = 1'b0;
      end
   end

   fsmatch_window #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_window (
      .clock   (clock),
      .win_ctl (win_ctl),
      .pat_len (len_ff),
      .match   (win_match)
   );

   // Main update. A pattern item appends to the pattern (starting over after a
   // last mark or after target items, flagging overflow when full) and abandons
   // any target in progress. A target item shifts the window, counts the byte,
   // and checks the full pattern against the newest bytes. Only the first match
   // of a target is reported; a target that ends without one reports not found,
   // or a bad-pattern status when the pattern is empty or overflowed.
   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      restart_in   = restart_ff;
      seen_in      = seen_ff;
      matched_in   = matched_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      found_hit    = 1'b0;

      win_ctl           = '0;
      win_ctl.data_byte = s1_item_ff.data_byte;

      len_eff   = restart_ff ? '0 : len_ff;
      pat_ok    = (len_ff != '0) && !ovf_ff;
      was_sat   = (seen_ff == fsmatch_pkg::OFFSET_MAX);
      seen_next = was_sat ? seen_ff : seen_ff + 1'b1;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (go) begin
         if (s1_item_ff.operation == fsmatch_pkg::OP_PATTERN) begin
            seen_in    = '0;
            matched_in = 1'b0;
            restart_in = s1_item_ff.last;
            ovf_in     = restart_ff ? 1'b0 : ovf_ff;
            if (len_eff < LEN_W'(MAX_PATTERN)) begin
               len_in            = len_eff + 1'b1;
               win_ctl.pat_shift = 1'b1;
            end else begin
               len_in = len_eff;
               ovf_in = 1'b1;
            end
         end else begin
            restart_in        = 1'b1;
            win_ctl.tgt_shift = 1'b1;
            seen_in           = seen_next;
            if (pat_ok && !matched_ff && (seen_next >= OFS_W'(len_ff)) && win_match) begin
               found_hit                = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = fsmatch_pkg::ST_FOUND;
               rsp_data_in.match_offset = was_sat ? fsmatch_pkg::OFFSET_MAX
                                                  : seen_next - OFS_W'(len_ff);
               if (s1_item_ff.last) begin
                  seen_in    = '0;
                  matched_in = 1'b0;
               end else begin
                  matched_in = 1'b1;
               end
            end else if (s1_item_ff.last) begin
               seen_in    = '0;
               matched_in = 1'b0;
               if (!matched_ff) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.status       = pat_ok ? fsmatch_pkg::ST_NOT_FOUND
                                                    : fsmatch_pkg::ST_BAD_PATTERN;
                  rsp_data_in.match_offset = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         restart_ff   <= 1'b1;
         seen_ff      <= '0;
         matched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         restart_ff   <= restart_in;
         seen_ff      <= seen_in;
         matched_ff   <= matched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A reported match either marks the target as matched or ends it.
   assert property (@(posedge clock) disable iff (reset)
      found_hit |=> (matched_ff || (seen_ff == '0)))
      else $error("match not recorded after found result");

   // Overflow only ever happens with the pattern store full.
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LEN_W'(MAX_PATTERN)))
      else $error("pattern overflow with short pattern");

   // A matched target has seen at least a whole non-empty pattern.
   assert property (@(posedge clock) disable iff (reset)
      matched_ff |-> ((len_ff != '0) && (seen_ff >= OFS_W'(len_ff))))
      else $error("matched state inconsistent with byte count");

endmodule
